### rtl/vilt_pkg.sv
// ----------------------------------------------------------------------------
// vilt_pkg
// Shared types and constants for the video interface line timer.
// ----------------------------------------------------------------------------
package vilt_pkg;

	localparam int NUM_REGS_DEF = 14;
	localparam int DATA_W       = 32;
	localparam int DIV_STEPS    = 32;
	localparam int CNT_W        = $clog2(DIV_STEPS);

	// function codes
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FRAME = 2'd2;

	// register indexes
	localparam logic [3:0] REG_STATUS  = 4'd0;
	localparam logic [3:0] REG_WIDTH   = 4'd2;
	localparam logic [3:0] REG_CURRENT = 4'd4;
	localparam logic [3:0] REG_VSYNC   = 4'd6;

	// configuration register indexes
	localparam logic CFG_TICKS = 1'b0;
	localparam logic CFG_ALT   = 1'b1;

	localparam logic [DATA_W-1:0] LINE_MODULUS   = 32'd526;
	localparam logic [DATA_W-1:0] DEFAULT_PERIOD = 32'd500000;
	localparam logic [DATA_W-1:0] RESET_PERIOD   = 32'd5000;
	localparam logic [DATA_W-1:0] RESET_TICKS    = 32'd1;
	localparam int                STATUS_FIELD_BIT = 6;

	typedef struct packed {
		logic [1:0]        func;
		logic [3:0]        reg_index;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] write_mask;
		logic [DATA_W-1:0] cpu_count;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              status_changed;
		logic              width_changed;
		logic              irq_raise;
		logic              irq_clear;
		logic [DATA_W-1:0] next_frame_at;
	} out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WB
	} state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic line_read;
		logic div_last;
	} dp_stat_t;

endpackage

### rtl/vilt_ctrl.sv
// ----------------------------------------------------------------------------
// vilt_ctrl
// Sequencer: takes a word, runs setup, divide (current-line reads only) and writeback, owns out valid.
// ----------------------------------------------------------------------------
module vilt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vilt_pkg::ctrl_cmd_t  cmd,
	input  vilt_pkg::dp_stat_t   stat
);
	import vilt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = stat.line_read ? S_DIV : S_WB;
			end
			S_DIV: begin
				if (stat.div_last) state_d = S_WB;
			end
			S_WB: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EXEC: cmd.load   = 1'b1;
			S_DIV:  cmd.step   = 1'b1;
			S_WB:   cmd.commit = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/vilt_dp.sv
// ----------------------------------------------------------------------------
// vilt_dp
// Datapath: register bank, frame timing, restoring divider, result register.
// ----------------------------------------------------------------------------
module vilt_dp #(
	parameter int NUM_REGS = vilt_pkg::NUM_REGS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_index,
	input  logic [vilt_pkg::DATA_W-1:0] cfg_data,
	input  vilt_pkg::in_t               in_data,
	output vilt_pkg::out_t              out_data,
	input  vilt_pkg::ctrl_cmd_t         cmd,
	output vilt_pkg::dp_stat_t          stat
);
	import vilt_pkg::*;

	localparam int         IDX_W      = $clog2(NUM_REGS);
	localparam logic [4:0] NUM_REGS_C = 5'(NUM_REGS);

	in_t               item_q;
	logic [DATA_W-1:0] bank_q [NUM_REGS];
	logic              field_q;
	logic [DATA_W-1:0] period_q;
	logic [DATA_W-1:0] next_q;
	logic [DATA_W-1:0] ticks_q;
	logic              alt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] prod_q;
	out_t              out_q;

	logic [IDX_W-1:0]  idx;
	logic              idx_ok;
	logic [DATA_W-1:0] cur;
	logic [DATA_W-1:0] elapsed;
	logic [DATA_W-1:0] vsync;
	logic [DATA_W-1:0] status;
	logic [DATA_W-1:0] vs_plus;
	logic [DATA_W-1:0] prod_full;
	logic [DATA_W:0]   rem_shift;
	logic [DATA_W+1:0] trial;
	logic              fits;
	logic [DATA_W-1:0] line_raw;
	logic [DATA_W-1:0] line;
	logic [DATA_W-1:0] merged;
	logic              mask_diff;
	logic [DATA_W-1:0] new_next;
	logic              bank_we;
	logic [DATA_W-1:0] bank_wd;
	out_t              res;

	assign idx     = item_q.reg_index[IDX_W-1:0];
	assign idx_ok  = {1'b0, item_q.reg_index} < NUM_REGS_C;
	assign cur     = idx_ok ? bank_q[idx] : '0;
	assign vsync   = bank_q[REG_VSYNC[IDX_W-1:0]];
	assign status  = bank_q[REG_STATUS[IDX_W-1:0]];
	assign elapsed = period_q - (next_q - item_q.cpu_count);

	// frame period product, low word only
	assign vs_plus   = vsync + 32'd1;
	assign prod_full = vs_plus * ticks_q;

	// restoring divide step, quotient bits shift into the dividend register
	assign rem_shift = {rem_q, quo_q[DATA_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, divisor_q};
	assign fits      = !trial[DATA_W+1];

	assign line_raw = alt_q ? rem_q : quo_q;
	assign line     = {line_raw[DATA_W-1:1], field_q};

	assign merged    = (cur & ~item_q.write_mask) | (item_q.write_data & item_q.write_mask);
	assign mask_diff = (cur & item_q.write_mask) != (item_q.write_data & item_q.write_mask);
	assign new_next  = next_q + prod_q;

	always_comb begin
		res               = '0;
		res.next_frame_at = next_q;
		bank_we           = 1'b0;
		bank_wd           = merged;
		case (item_q.func)
			FUNC_READ: begin
				if (idx_ok) begin
					if (item_q.reg_index == REG_CURRENT) begin
						res.read_data = line;
						bank_we       = 1'b1;
						bank_wd       = line;
					end else begin
						res.read_data = cur;
					end
				end
			end
			FUNC_WRITE: begin
				if (idx_ok) begin
					if (item_q.reg_index == REG_STATUS) begin
						res.status_changed = mask_diff;
						bank_we            = mask_diff;
					end else if (item_q.reg_index == REG_WIDTH) begin
						res.width_changed = mask_diff;
						bank_we           = mask_diff;
					end else if (item_q.reg_index == REG_CURRENT) begin
						res.irq_clear = 1'b1;
					end else begin
						bank_we = 1'b1;
					end
				end
			end
			FUNC_FRAME: begin
				res.irq_raise     = 1'b1;
				res.next_frame_at = new_next;
			end
			default: res.next_frame_at = next_q;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) bank_q[i] <= '0;
			field_q  <= 1'b0;
			period_q <= RESET_PERIOD;
			next_q   <= RESET_PERIOD;
			ticks_q  <= RESET_TICKS;
			alt_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TICKS: ticks_q <= cfg_data;
					CFG_ALT:   alt_q   <= cfg_data[0];
					default:   alt_q   <= alt_q;
				endcase
			end
			if (cmd.commit) begin
				if (bank_we) bank_q[idx] <= bank_wd;
				if (item_q.func == FUNC_FRAME) begin
					field_q  <= field_q ^ status[STATUS_FIELD_BIT];
					period_q <= prod_q;
					next_q   <= new_next;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_data;
		if (cmd.load) begin
			rem_q     <= '0;
			quo_q     <= elapsed;
			divisor_q <= alt_q ? LINE_MODULUS : ticks_q;
			cnt_q     <= '0;
			prod_q    <= (vsync == '0) ? DEFAULT_PERIOD : prod_full;
		end
		if (cmd.step) begin
			rem_q <= fits ? trial[DATA_W-1:0] : rem_shift[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.commit) out_q <= res;
	end

	assign stat.line_read = (item_q.func == FUNC_READ) && (item_q.reg_index == REG_CURRENT);
	assign stat.div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign out_data       = out_q;

endmodule

### rtl/video_interface_line_timer.sv
// ----------------------------------------------------------------------------
// video_interface_line_timer
// Video interface register bank with scanline counter and frame timing.
// ----------------------------------------------------------------------------
//  port group   direction  handshake               payload
//  in_*         input      in_valid / in_ready     in_data   (vilt_pkg::in_t)
//  out_*        output     out_valid / out_ready   out_data  (vilt_pkg::out_t)
//  cfg_*        input      cfg_wr_en               cfg_index, cfg_data
//
//  a current-line read passes through accept, setup, 32 steps of the one-bit
//  restoring divider and writeback; other words go from setup straight to writeback.
//  one word is in flight at a time; a finished word waits in the output
//  register while the next word is accepted and worked on.
//  writeback stalls while the output register is still held by out_ready low.
//  reset is asynchronous; the bank clears to zero, period and next frame to 5000.
// ----------------------------------------------------------------------------
module video_interface_line_timer #(
	parameter int NUM_REGS = vilt_pkg::NUM_REGS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vilt_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vilt_pkg::out_t              out_data,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_index,
	input  logic [vilt_pkg::DATA_W-1:0] cfg_data
);
	import vilt_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	vilt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	vilt_dp #(
		.NUM_REGS (NUM_REGS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### rtl/vilt_chk.sv
// ----------------------------------------------------------------------------
// vilt_chk
// Port-level checks for the line timer, bound to the top level.
// ----------------------------------------------------------------------------
module vilt_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input vilt_pkg::out_t              out_data
);
	import vilt_pkg::*;

	// a held result word keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// one word at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");

	// a word carries at most one event flag
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({out_data.status_changed, out_data.width_changed,
			out_data.irq_raise, out_data.irq_clear}) <= 1)
		else $error("more than one event flag");

	// read data only on a read, which raises no flag
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.read_data != '0) |-> !out_data.status_changed &&
			!out_data.width_changed && !out_data.irq_raise && !out_data.irq_clear)
		else $error("read data alongside an event flag");

	// no result right after an accept from idle
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind video_interface_line_timer vilt_chk u_vilt_chk (.*);
